### rtl/cma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cma_pkg;

	localparam int unsigned YEAR_W   = 14;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned DAY_W    = 5;
	localparam int unsigned HOUR_W   = 5;
	localparam int unsigned MINUTE_W = 6;
	localparam int unsigned TDATA_W  = 40;

	localparam logic [6:0]  MINUTES_PER_HOUR = 7'd60;
	localparam logic [5:0]  HOURS_PER_DAY    = 6'd24;
	localparam logic [4:0]  MONTHS_PER_YEAR  = 5'd12;
	localparam logic [14:0] YEAR_LIMIT       = 15'd9999;

	// 25 * 3113 = 1 mod 4096; x is a multiple of 25 iff x * 3113 mod 4096 <= 4095 / 25
	localparam logic [11:0] INV25_MOD4096 = 12'd3113;
	localparam logic [11:0] DIV25_MAX     = 12'd163;

	typedef struct packed {
		logic [5:0]          add_minutes;
		logic [MINUTE_W-1:0] minute;
		logic [HOUR_W-1:0]   hour;
		logic [DAY_W-1:0]    day;
		logic [MONTH_W-1:0]  month;
		logic [YEAR_W-1:0]   year;
	} time_in_t;

	typedef struct packed {
		logic [MINUTE_W-1:0] minute;
		logic [HOUR_W-1:0]   hour;
		logic [DAY_W-1:0]    day;
		logic [MONTH_W-1:0]  month;
		logic [YEAR_W-1:0]   year;
	} time_out_t;

	function automatic logic div_by_25(input logic [11:0] x);
		logic [23:0] prod;
		begin
			prod = {12'd0, x} * {12'd0, INV25_MOD4096};
			return prod[11:0] <= DIV25_MAX;
		end
	endfunction

	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic by4;
		logic by100;
		logic by400;
		begin
			by4   = (y[1:0] == 2'd0);
			by100 = by4 && div_by_25(y[13:2]);
			by400 = (y[3:0] == 4'd0) && div_by_25({2'd0, y[13:4]});
			return (by4 && !by100) || by400;
		end
	endfunction

	// months without a length (0, 13..15) take the February figure
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic [YEAR_W-1:0] y);
		logic [DAY_W-1:0] len;
		begin
			case (m)
				4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
				4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
				default: len = is_leap(y) ? 5'd29 : 5'd28;
			endcase
			return len;
		end
	endfunction

endpackage

`default_nettype wire

### rtl/calendar_minute_advance.sv
`timescale 1ns / 1ps
`default_nettype none

// Calendar minute advance: adds 0..59 minutes to a Gregorian date and time and
// ripples the carry through hour, day, month and year (leap years by the
// 4/100/400 rule, year 9999 wraps to 0). Each request is registered on entry,
// worked out by combinational carry logic and registered again on exit once
// the output side can take it; one request is taken every cycle while the
// output side keeps up. While a finished result waits at the output the entry
// stage takes one more request, then holds off.
module calendar_minute_advance (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// year_in[13:0], month_in[17:14], day_in[22:18], hour_in[27:23],
	// minute_in[33:28], add_minutes[39:34]
	input  wire logic [39:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// year_out[13:0], month_out[17:14], day_out[22:18], hour_out[27:23],
	// minute_out[33:28], zero[39:34]
	output logic [39:0]      m_tdata
);

	cma_pkg::time_in_t  data_s1;
	cma_pkg::time_out_t data_s2;
	cma_pkg::time_out_t res;
	logic               valid_s1;
	logic               valid_s2;
	logic               advance;

	logic [6:0]  min_sum;
	logic [6:0]  min_wrap;
	logic        carry_h;
	logic [5:0]  hour_inc;
	logic        carry_d;
	logic [5:0]  day_inc;
	logic [4:0]  mdays;
	logic        carry_m;
	logic [4:0]  mon_inc;
	logic        carry_y;
	logic [14:0] year_inc;

	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			data_s1 <= cma_pkg::time_in_t'(s_tdata);
		if (advance && valid_s1)
			data_s2 <= res;
	end

	// each stage is tested whether or not a carry came in
	always_comb begin
		min_sum  = {1'b0, data_s1.minute} + {1'b0, data_s1.add_minutes};
		carry_h  = (min_sum >= cma_pkg::MINUTES_PER_HOUR);
		min_wrap = min_sum - cma_pkg::MINUTES_PER_HOUR;
		hour_inc = {1'b0, data_s1.hour} + {5'd0, carry_h};
		carry_d  = (hour_inc >= cma_pkg::HOURS_PER_DAY);
		day_inc  = {1'b0, data_s1.day} + {5'd0, carry_d};
		mdays    = cma_pkg::month_len(data_s1.month, data_s1.year);
		carry_m  = (day_inc > {1'b0, mdays});
		mon_inc  = {1'b0, data_s1.month} + {4'd0, carry_m};
		carry_y  = (mon_inc > cma_pkg::MONTHS_PER_YEAR);
		year_inc = {1'b0, data_s1.year} + {14'd0, carry_y};

		res.minute = carry_h ? min_wrap[5:0] : min_sum[5:0];
		res.hour   = carry_d ? 5'd0 : hour_inc[4:0];
		res.day    = carry_m ? 5'd1 : day_inc[4:0];
		res.month  = carry_y ? 4'd1 : mon_inc[3:0];
		res.year   = (carry_y && (year_inc > cma_pkg::YEAR_LIMIT)) ? 14'd0 : year_inc[13:0];
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, data_s2};

	a_idle_entry_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("entry stage empty but request refused");

	a_entry_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(data_s1))
		else $error("entry stage lost its request during a stall");

	a_entry_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> m_tvalid)
		else $error("request left entry stage but no result appeared");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 && advance |=> !m_tvalid)
		else $error("result appeared without a request");

endmodule

`default_nettype wire
